@@ src/quadratic_root_solver_top_assert.svh @@
// Assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/qrs_pkg.sv @@
// Shared constants and types for the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int COEF_WIDTH = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_WIDTH  = 35;
   localparam int RSP_DATA_W = ((2 * OUT_WIDTH + 7) / 8) * 8;

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_DOUBLE   = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_A_ZERO   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     neg_first;
      logic     neg_second;
   } div_side_type;
endpackage

@@ src/qrs_sqrt_cell.sv @@
// One bit step of the pipelined integer square root
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 34
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2*ROOT_W-1:0]   rad_i,
   input  logic [ROOT_W+1:0]     rem_i,
   input  logic [ROOT_W-1:0]     root_i,
   input  logic [SIDE_W-1:0]     side_i,
   output logic [2*ROOT_W-1:0]   rad_o,
   output logic [ROOT_W+1:0]     rem_o,
   output logic [ROOT_W-1:0]     root_o,
   output logic [SIDE_W-1:0]     side_o
);
   logic [2*ROOT_W-1:0] rad_ff, rad_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [ROOT_W+1:0]   rem_sh, trial;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_i[ROOT_W-1:0], rad_i[2*ROOT_W-1 -: 2]};
      trial   = {root_i, 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? (rem_sh - trial) : rem_sh;
      root_in = {root_i[ROOT_W-2:0], ge};
      rad_in  = rad_i << 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= side_i;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign side_o = side_ff;
endmodule

@@ src/qrs_div_cell.sv @@
// One quotient bit step of the two-lane restoring divider
`timescale 1ns / 1ps
module qrs_div_cell #(
   parameter int DIV_W  = 34,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 4
) (
   input  logic               clock,
   input  logic               en,
   input  logic [DEN_W-1:0]   den_i,
   input  logic [DIV_W-1:0]   sh_i  [2],
   input  logic [DEN_W:0]     rem_i [2],
   input  logic [SIDE_W-1:0]  side_i,
   output logic [DEN_W-1:0]   den_o,
   output logic [DIV_W-1:0]   sh_o  [2],
   output logic [DEN_W:0]     rem_o [2],
   output logic [SIDE_W-1:0]  side_o
);
   logic [DEN_W-1:0]  den_ff;
   logic [DIV_W-1:0]  sh_ff [2], sh_in [2];
   logic [DEN_W:0]    rem_ff [2], rem_in [2];
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      logic [DEN_W:0] r2;
      logic           ge;
      for (int l = 0; l < 2; l++) begin
         r2         = {rem_i[l][DEN_W-1:0], sh_i[l][DIV_W-1]};
         ge         = r2 >= {1'b0, den_i};
         rem_in[l]  = ge ? (r2 - {1'b0, den_i}) : r2;
         sh_in[l]   = {sh_i[l][DIV_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= den_i;
         sh_ff   <= sh_in;
         rem_ff  <= rem_in;
         side_ff <= side_i;
      end
   end

   assign den_o  = den_ff;
   assign sh_o   = sh_ff;
   assign rem_o  = rem_ff;
   assign side_o = side_ff;
endmodule

@@ src/quadratic_root_solver_top.sv @@
// Quadratic root solver: a chain of square root and divider cells, with the
// bit-per-cell square root (COEF_WIDTH+FRAC_BITS+1 cells) and divider
// (COEF_WIDTH+FRAC_BITS+2 cells). One transaction per cycle; a stalled result
// freezes the whole chain. Synchronous reset clears only the valid bits.
`timescale 1ns / 1ps
module quadratic_root_solver_top #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // coef_a, coef_b, coef_c
   input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // first_value, second_value
   output logic [qrs_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // root_kind
   output logic [1:0]                               rsp_tuser
);
   localparam int CW     = COEF_WIDTH;
   localparam int OUT_W  = qrs_pkg::OUT_WIDTH;
   localparam int MAG_W  = 2 * CW + 1;
   localparam int R_W    = CW + FRAC_BITS + 1;
   localparam int DIV_W  = CW + FRAC_BITS + 2;
   localparam int NS_W   = DIV_W + 1;
   localparam int DEN_W  = CW + 1;
   localparam int SQ_SW  = 2 + 2 * CW;
   localparam int DV_SW  = $bits(qrs_pkg::div_side_type);
   localparam int NST    = R_W + DIV_W + 4;
   localparam int CMP_W  = (DIV_W > OUT_W ? DIV_W : OUT_W) + 1;
   localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << (OUT_W - 1);

   logic en;
   logic [NST-1:0] vld_ff, vld_in;

   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // products
   logic signed [CW-1:0] a_s, b_s, c_s;
   logic [CW-1:0]        a_mag, b_mag, c_mag;
   logic [2*CW-1:0]      pb_ff, pb_in, pac_ff, pac_in;
   logic signed [CW-1:0] a0_ff, b0_ff;
   logic                 opp_ff, opp_in;

   always_comb begin
      a_s    = req_tdata[CW-1:0];
      b_s    = req_tdata[2*CW-1:CW];
      c_s    = req_tdata[3*CW-1:2*CW];
      a_mag  = a_s[CW-1] ? (~a_s + 1'b1) : a_s;
      b_mag  = b_s[CW-1] ? (~b_s + 1'b1) : b_s;
      c_mag  = c_s[CW-1] ? (~c_s + 1'b1) : c_s;
      pb_in  = b_mag * b_mag;
      pac_in = a_mag * c_mag;
      opp_in = a_s[CW-1] != c_s[CW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pb_ff  <= pb_in;
         pac_ff <= pac_in;
         opp_ff <= opp_in;
         a0_ff  <= a_s;
         b0_ff  <= b_s;
      end
   end

   // discriminant magnitude and kind
   logic [MAG_W-1:0]     mag_ff, mag_in, p_x, q4_x;
   qrs_pkg::kind_type    kind1_ff, kind1_in;
   logic signed [CW-1:0] a1_ff, b1_ff;

   always_comb begin
      p_x  = MAG_W'(pb_ff);
      q4_x = MAG_W'({pac_ff, 2'b00});
      if (opp_ff) begin
         mag_in   = p_x + q4_x;
         kind1_in = qrs_pkg::KIND_TWO_REAL;
      end else if (p_x >= q4_x) begin
         mag_in   = p_x - q4_x;
         kind1_in = qrs_pkg::KIND_TWO_REAL;
      end else begin
         mag_in   = q4_x - p_x;
         kind1_in = qrs_pkg::KIND_COMPLEX;
      end
      if (a0_ff == '0) begin
         kind1_in = qrs_pkg::KIND_A_ZERO;
      end else if (mag_in == '0) begin
         kind1_in = qrs_pkg::KIND_DOUBLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         kind1_ff <= kind1_in;
         a1_ff    <= a0_ff;
         b1_ff    <= b0_ff;
      end
   end

   // square root chain
   logic [2*R_W-1:0] sq_rad  [R_W+1];
   logic [R_W+1:0]   sq_rem  [R_W+1];
   logic [R_W-1:0]   sq_root [R_W+1];
   logic [SQ_SW-1:0] sq_side [R_W+1];

   assign sq_rad[0]  = (2*R_W)'(mag_ff) << (2 * FRAC_BITS);
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = {kind1_ff, a1_ff, b1_ff};

   for (genvar i = 0; i < R_W; i++) begin : g_sqrt
      qrs_sqrt_cell #(.ROOT_W(R_W), .SIDE_W(SQ_SW)) u_cell (
         .clock  (clock),
         .en     (en),
         .rad_i  (sq_rad[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .side_i (sq_side[i]),
         .rad_o  (sq_rad[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1]),
         .side_o (sq_side[i+1])
      );
   end

   // numerators, signs and divisor
   qrs_pkg::kind_type    kind2;
   logic signed [CW-1:0] a2, b2;
   logic [CW-1:0]        a2_mag;
   logic signed [NS_W-1:0] nb, s_x, n1, n2;
   logic [DIV_W-1:0]     m1_ff, m1_in, m2_ff, m2_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   qrs_pkg::div_side_type dside_ff, dside_in;

   always_comb begin
      {kind2, a2, b2} = sq_side[R_W];
      a2_mag = a2[CW-1] ? (~a2 + 1'b1) : a2;
      nb     = -(NS_W'(b2) <<< FRAC_BITS);
      s_x    = NS_W'(signed'({1'b0, sq_root[R_W]}));
      n1     = nb;
      n2     = nb;
      if (kind2 == qrs_pkg::KIND_TWO_REAL) begin
         n1 = nb + s_x;
         n2 = nb - s_x;
      end else if (kind2 == qrs_pkg::KIND_COMPLEX) begin
         n2 = s_x;
      end
      m1_in = n1[NS_W-1] ? DIV_W'(-n1) : DIV_W'(n1);
      m2_in = n2[NS_W-1] ? DIV_W'(-n2) : DIV_W'(n2);
      den_in = {a2_mag, 1'b0};
      dside_in.kind       = kind2;
      dside_in.neg_first  = n1[NS_W-1] ^ a2[CW-1];
      dside_in.neg_second = n2[NS_W-1] ^ a2[CW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         den_ff   <= den_in;
         dside_ff <= dside_in;
      end
   end

   // divider chain, two lanes
   logic [DEN_W-1:0] dv_den  [DIV_W+1];
   logic [DIV_W-1:0] dv_sh   [DIV_W+1][2];
   logic [DEN_W:0]   dv_rem  [DIV_W+1][2];
   logic [DV_SW-1:0] dv_side [DIV_W+1];

   assign dv_den[0]    = den_ff;
   assign dv_sh[0][0]  = m1_ff;
   assign dv_sh[0][1]  = m2_ff;
   assign dv_rem[0][0] = '0;
   assign dv_rem[0][1] = '0;
   assign dv_side[0]   = dside_ff;

   for (genvar i = 0; i < DIV_W; i++) begin : g_div
      qrs_div_cell #(.DIV_W(DIV_W), .DEN_W(DEN_W), .SIDE_W(DV_SW)) u_cell (
         .clock  (clock),
         .en     (en),
         .den_i  (dv_den[i]),
         .sh_i   (dv_sh[i]),
         .rem_i  (dv_rem[i]),
         .side_i (dv_side[i]),
         .den_o  (dv_den[i+1]),
         .sh_o   (dv_sh[i+1]),
         .rem_o  (dv_rem[i+1]),
         .side_o (dv_side[i+1])
      );
   end

   // saturate and output register
   function automatic logic [OUT_W-1:0] sat_pack(input logic [DIV_W-1:0] q, input logic neg);
      logic [CMP_W-1:0] qx;
      logic [CMP_W-1:0] r;
      qx = CMP_W'(q);
      if (neg) begin
         if (qx > LIM) qx = LIM;
         r = -qx;
      end else begin
         if (qx > LIM - 1'b1) qx = LIM - 1'b1;
         r = qx;
      end
      return r[OUT_W-1:0];
   endfunction

   qrs_pkg::div_side_type fside;
   qrs_pkg::kind_type     kind_ff;
   logic [OUT_W-1:0]      first_ff, first_in, second_ff, second_in;

   always_comb begin
      fside     = dv_side[DIV_W];
      first_in  = sat_pack(dv_sh[DIV_W][0], fside.neg_first);
      second_in = sat_pack(dv_sh[DIV_W][1], fside.neg_second);
      if (fside.kind == qrs_pkg::KIND_A_ZERO) begin
         first_in  = '0;
         second_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff   <= fside.kind;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = qrs_pkg::RSP_DATA_W'({second_ff, first_ff});

`include "quadratic_root_solver_top_assert.svh"

   `QRS_ASSERT_NOW(a_zero_roots, clock, reset,
      rsp_tvalid && rsp_tuser == qrs_pkg::KIND_A_ZERO, first_ff == '0 && second_ff == '0,
      "degenerate equation gave nonzero roots")
   `QRS_ASSERT_NOW(double_root_same, clock, reset,
      rsp_tvalid && rsp_tuser == qrs_pkg::KIND_DOUBLE, first_ff == second_ff,
      "double root values differ")
   `QRS_ASSERT_NEXT(stall_freezes_chain, clock, reset,
      !en, $stable(vld_ff) && $stable(first_ff),
      "pipeline moved during stall")
endmodule

@@ test/quadratic_root_solver_top_tb.sv @@
// Self-checking testbench for the quadratic root solver: random and corner coefficient sets
`timescale 1ns / 1ps
module quadratic_root_solver_top_tb;

   localparam int REQ_W = ((3*qrs_pkg::COEF_WIDTH+7)/8)*8;
   localparam int LATENCY = 2*qrs_pkg::COEF_WIDTH + 2*qrs_pkg::FRAC_BITS + 7;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
   } coef_set_type;

   typedef struct packed {
      qrs_pkg::kind_type                 kind;
      logic [qrs_pkg::OUT_WIDTH-1:0]     first;
      logic [qrs_pkg::OUT_WIDTH-1:0]     second;
   } roots_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [qrs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   coef_set_type pending_sets[$];
   roots_type    expected_roots[$];
   int  send_idle_pct = 13;
   int  recv_idle_pct = 55;
   int  hold_off = 0;
   bit  req_taken = 1'b0;
   int  mismatches = 0;
   int  idle_cycles = 0;

   quadratic_root_solver_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // quotient by 2a, truncated toward zero and saturated to the output range
   function automatic logic [qrs_pkg::OUT_WIDTH-1:0] div_by_two_a(longint num, longint a);
      longint unsigned den, quo, lim;
      bit neg;
      den = (a < 0 ? -a : a) * 2;
      quo = longint'(num < 0 ? -num : num) / den;
      neg = (num < 0) != (a < 0);
      lim = 64'd1 << (qrs_pkg::OUT_WIDTH - 1);
      if (neg) begin
         if (quo > lim) quo = lim;
         return qrs_pkg::OUT_WIDTH'(-quo);
      end
      if (quo > lim - 1) quo = lim - 1;
      return qrs_pkg::OUT_WIDTH'(quo);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [127:0] n);
      logic [127:0] res, bitv, t;
      res = '0;
      bitv = 128'd1 << 126;
      while (bitv != 0 && bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = res + bitv;
         if (n >= t) begin
            n = n - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[63:0];
   endfunction

   function automatic roots_type solve_roots(coef_set_type cs);
      roots_type r;
      longint a, b, c, disc, nb, s;
      a = cs.a; b = cs.b; c = cs.c;
      if (a == 0) begin
         r.kind = qrs_pkg::KIND_A_ZERO; r.first = '0; r.second = '0;
         return r;
      end
      disc = b*b - 4*a*c;
      s = longint'(floor_sqrt(128'(disc < 0 ? -disc : disc) << (2*qrs_pkg::FRAC_BITS)));
      nb = -b * (longint'(1) << qrs_pkg::FRAC_BITS);
      if (disc < 0) begin
         r.kind = qrs_pkg::KIND_COMPLEX;
         r.first = div_by_two_a(nb, a);
         r.second = div_by_two_a(s, a);
      end else if (disc == 0) begin
         r.kind = qrs_pkg::KIND_DOUBLE;
         r.first = div_by_two_a(nb, a);
         r.second = r.first;
      end else begin
         r.kind = qrs_pkg::KIND_TWO_REAL;
         r.first = div_by_two_a(nb + s, a);
         r.second = div_by_two_a(nb - s, a);
      end
      return r;
   endfunction

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   // acceptance seen at the rising edge, used by the driver at the next falling edge
   always @(posedge clock) req_taken <= req_tvalid && req_tready;

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_sets.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata <= REQ_W'({pending_sets[0].c, pending_sets[0].b, pending_sets[0].a});
               req_tvalid <= 1'b1;
               expected_roots.push_back(solve_roots(pending_sets.pop_front()));
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= (hold_off == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) if (hold_off > 0) hold_off <= hold_off - 1;

   // monitor and watchdog
   always @(posedge clock) begin
      roots_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL quadratic_root_solver_top");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result transaction %h", rsp_tdata);
            end else begin
               want = expected_roots.pop_front();
               if (rsp_tuser !== want.kind ||
                   rsp_tdata[qrs_pkg::OUT_WIDTH-1:0] !== want.first ||
                   rsp_tdata[2*qrs_pkg::OUT_WIDTH-1:qrs_pkg::OUT_WIDTH] !== want.second) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: kind %0d/%0d first %h/%h second %h/%h",
                        want.kind, rsp_tuser, want.first,
                        rsp_tdata[qrs_pkg::OUT_WIDTH-1:0], want.second,
                        rsp_tdata[2*qrs_pkg::OUT_WIDTH-1:qrs_pkg::OUT_WIDTH]);
               end
            end
         end
      end
   end

   task automatic queue_set(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      pending_sets.push_back('{a, b, c});
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) queue_set(pick_coef(), pick_coef(), pick_coef());
   endtask

   task automatic wait_drained();
      while (pending_sets.size() > 0 || req_tvalid) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // directed: each root kind, extremes, negative a
      queue_set(16'd1, -16'sd3, 16'd2);
      queue_set(16'd1, 16'd2, 16'd1);
      queue_set(16'd1, 16'd0, 16'd1);
      queue_set(-16'sd1, 16'd0, 16'd1);
      queue_set(-16'sd2, 16'd1, -16'sd5);
      queue_set(16'd0, 16'd5, 16'd7);
      queue_set(16'd0, 16'h8000, 16'h7fff);
      queue_set(16'h8000, 16'h8000, 16'h8000);
      queue_set(16'h7fff, 16'h7fff, 16'h7fff);
      queue_set(16'h8000, 16'h7fff, 16'h7fff);
      queue_set(16'd1, 16'h8000, 16'h8000);
      queue_set(16'd1, 16'h7fff, 16'd0);
      queue_set(16'hffff, 16'hffff, 16'hffff);
      queue_set(16'd3, 16'd0, 16'd0);
      queue_set(16'd1, 16'd0, 16'h8000);
      queue_set(16'h7fff, 16'd0, 16'h7fff);
      queue_set(16'd4, 16'd4, 16'd1);
      queue_set(16'd5, 16'd1, 16'h8000);
      queue_random(RANDOM_ITEMS / 3);
      wait_drained();
      // long receiver stall while the sender keeps offering
      hold_off = 400;
      send_idle_pct = 55; recv_idle_pct = 13;
      queue_random(RANDOM_ITEMS / 3);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(RANDOM_ITEMS / 3);
      wait_drained();
      while (expected_roots.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) $display("PASS quadratic_root_solver_top");
      else $display("FAIL quadratic_root_solver_top");
      $finish;
   end
endmodule
